@@ sv/ppds_pkg.sv @@
// Shared types, constants and operation codes of the palette pixel depth shader.
package ppds_pkg;

    localparam int NUM_COLORS = 256;
    localparam int IDX_W      = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;

    localparam int LABEL_W = 16;
    localparam int DEPTH_W = 16;
    localparam int CH_W    = 8;
    localparam int RGB_W   = 3 * CH_W;

    // Depth factor datapath widths
    localparam int Q_W        = 16;
    localparam int KD_W       = 20;
    localparam int DEN_W      = 21;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;
    localparam int PROD_W     = CH_W + Q_W;

    localparam logic [Q_W-1:0]  F_FLAT_MAT  = 16'd32768;
    localparam logic [Q_W-1:0]  F_FLAT_BODY = 16'd39321;
    localparam logic [CH_W-1:0] CH_MAX      = 8'd255;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SHADE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [1:0] CFG_BODY_VIEW     = 2'd0;
    localparam logic [1:0] CFG_DEPTH_SHADING = 2'd1;
    localparam logic [1:0] CFG_MIN_DEPTH     = 2'd2;
    localparam logic [1:0] CFG_MAX_DEPTH     = 2'd3;

    typedef struct packed {
        logic            vld;
        logic [1:0]      op;
        logic            ok;
        logic            vis;
        logic            shade;
        logic            body;
        logic            empty;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_ctl;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   nlo;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
    } t_div;

endpackage

@@ sv/ppds_front.sv @@
// Front end: depth range math, palette memory, visible map, and divider setup.
module ppds_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [1:0]                    i_opcode,
    input  logic [ppds_pkg::LABEL_W-1:0]  i_label,
    input  logic [ppds_pkg::DEPTH_W-1:0]  i_depth,
    input  logic [ppds_pkg::CH_W-1:0]     i_write_red,
    input  logic [ppds_pkg::CH_W-1:0]     i_write_green,
    input  logic [ppds_pkg::CH_W-1:0]     i_write_blue,
    input  logic                          i_body_view,
    input  logic                          i_depth_shading,
    input  logic [ppds_pkg::DEPTH_W-1:0]  i_min_depth,
    input  logic [ppds_pkg::DEPTH_W-1:0]  i_max_depth,
    output ppds_pkg::t_ctl                o_ctl,
    output ppds_pkg::t_div                o_div
);

    logic                          accept;
    logic                          ok;
    logic [ppds_pkg::IDX_W-1:0]    idx;
    logic [ppds_pkg::DEPTH_W-1:0]  dclamp;
    logic                          empty;

    logic [ppds_pkg::RGB_W-1:0]    r_pal_mem [ppds_pkg::NUM_COLORS];
    logic [ppds_pkg::NUM_COLORS-1:0] r_pal_vld;
    logic [ppds_pkg::NUM_COLORS-1:0] r_vis_map;
    logic [ppds_pkg::RGB_W-1:0]    r_pal_rd;
    logic                          r_pal_rd_vld;

    ppds_pkg::t_ctl                r_s1_ctl, n_s1_ctl;
    logic [ppds_pkg::DEPTH_W-1:0]  r_s1_n, r_s1_d;

    ppds_pkg::t_ctl                r_s2_ctl, n_s2_ctl;
    ppds_pkg::t_div                r_s2_div, n_s2_div;

    logic [ppds_pkg::KD_W-1:0]     d20;
    logic [ppds_pkg::KD_W-1:0]     kd;
    logic [ppds_pkg::DEN_W-1:0]    d21, n21, cn;
    logic [ppds_pkg::RGB_W-1:0]    pal_color;

    assign accept = i_valid && i_en;
    assign ok     = {1'b0, i_label} < (ppds_pkg::LABEL_W + 1)'(ppds_pkg::NUM_COLORS);
    assign idx    = i_label[ppds_pkg::IDX_W-1:0];
    assign empty  = i_max_depth <= i_min_depth;

    always_comb begin
        if (i_depth < i_min_depth) begin
            dclamp = i_min_depth;
        end else if (i_depth > i_max_depth) begin
            dclamp = i_max_depth;
        end else begin
            dclamp = i_depth;
        end
    end

    always_comb begin
        n_s1_ctl       = '0;
        n_s1_ctl.vld   = i_valid;
        n_s1_ctl.op    = i_opcode;
        n_s1_ctl.ok    = ok;
        n_s1_ctl.vis   = (i_opcode == ppds_pkg::OP_QUERY) && ok && r_vis_map[idx];
        n_s1_ctl.shade = i_depth_shading;
        n_s1_ctl.body  = i_body_view;
        n_s1_ctl.empty = empty;
    end

    // Palette storage: write and registered read on the accepting edge
    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == ppds_pkg::OP_WRITE) && ok) begin
            r_pal_mem[idx] <= {i_write_red, i_write_green, i_write_blue};
        end
        if (accept) begin
            r_pal_rd <= r_pal_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld    <= '0;
            r_pal_rd_vld <= 1'b0;
            r_vis_map    <= '0;
        end else if (accept) begin
            r_pal_rd_vld <= r_pal_vld[idx];
            if ((i_opcode == ppds_pkg::OP_WRITE) && ok) begin
                r_pal_vld[idx] <= 1'b1;
            end
            if ((i_opcode == ppds_pkg::OP_SHADE) && ok) begin
                r_vis_map[idx] <= 1'b1;
            end
            if (i_opcode == ppds_pkg::OP_CLEAR) begin
                r_vis_map <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_n <= dclamp - i_min_depth;
            r_s1_d <= i_max_depth - i_min_depth;
        end
    end

    // Stage 2: scaled numerator and denominator, unwritten entries read as black
    assign pal_color = r_pal_rd_vld ? r_pal_rd : '0;
    assign d20       = ppds_pkg::KD_W'(r_s1_d);
    assign d21       = ppds_pkg::DEN_W'(r_s1_d);
    assign n21       = ppds_pkg::DEN_W'(r_s1_n);
    assign kd        = r_s1_ctl.body ? ((d20 << 3) + (d20 << 2)) : ((d20 << 3) + (d20 << 1));
    assign cn        = r_s1_ctl.body ? ((n21 << 4) + (n21 << 2)) : ((n21 << 3) + (n21 << 1) + n21);

    always_comb begin
        n_s2_ctl     = r_s1_ctl;
        n_s2_ctl.r   = pal_color[ppds_pkg::RGB_W-1 -: ppds_pkg::CH_W];
        n_s2_ctl.g   = pal_color[ppds_pkg::CH_W +: ppds_pkg::CH_W];
        n_s2_ctl.b   = pal_color[0 +: ppds_pkg::CH_W];
        n_s2_div.rem = ppds_pkg::DEN_W'(kd[ppds_pkg::KD_W-1:1]);
        n_s2_div.nlo = {kd[0], {(ppds_pkg::Q_W - 1){1'b0}}};
        n_s2_div.den = (d21 << 3) + (d21 << 1) + cn;
        n_s2_div.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (i_en) begin
            r_s2_ctl <= n_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_div <= n_s2_div;
        end
    end

    assign o_ctl = r_s2_ctl;
    assign o_div = r_s2_div;

endmodule

@@ sv/ppds_div_stage.sv @@
// One pipeline stage of the restoring divider for the depth factor.
module ppds_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ppds_pkg::t_ctl  i_ctl,
    input  ppds_pkg::t_div  i_div,
    output ppds_pkg::t_ctl  o_ctl,
    output ppds_pkg::t_div  o_div
);

    ppds_pkg::t_ctl r_ctl;
    ppds_pkg::t_div r_div, n_div;

    always_comb begin
        logic [ppds_pkg::DEN_W:0] sh;
        n_div = i_div;
        for (int i = 0; i < ppds_pkg::DIV_STEPS; i++) begin
            sh = {n_div.rem, n_div.nlo[ppds_pkg::Q_W-1]};
            if (sh >= {1'b0, n_div.den}) begin
                n_div.rem = ppds_pkg::DEN_W'(sh - {1'b0, n_div.den});
                n_div.q   = {n_div.q[ppds_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_div.rem = sh[ppds_pkg::DEN_W-1:0];
                n_div.q   = {n_div.q[ppds_pkg::Q_W-2:0], 1'b0};
            end
            n_div.nlo = {n_div.nlo[ppds_pkg::Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_ctl = r_ctl;
    assign o_div = r_div;

endmodule

@@ sv/ppds_scale.sv @@
// Channel scaling by the depth factor, saturation and the output register.
module ppds_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  ppds_pkg::t_ctl             i_ctl,
    input  logic [ppds_pkg::Q_W-1:0]   i_quot,
    output logic                       o_valid,
    output logic [ppds_pkg::CH_W-1:0]  o_red,
    output logic [ppds_pkg::CH_W-1:0]  o_green,
    output logic [ppds_pkg::CH_W-1:0]  o_blue,
    output logic                       o_in_range,
    output logic                       o_visible
);

    function automatic logic [ppds_pkg::CH_W-1:0] sat_ch(
        input logic [ppds_pkg::PROD_W-1:0] p
    );
        logic [ppds_pkg::PROD_W-16:0] v;
        v = p[ppds_pkg::PROD_W-1:15];
        if (v > (ppds_pkg::PROD_W - 15)'(ppds_pkg::CH_MAX)) begin
            return ppds_pkg::CH_MAX;
        end
        return v[ppds_pkg::CH_W-1:0];
    endfunction

    logic [ppds_pkg::Q_W-1:0]     fac;
    ppds_pkg::t_ctl               r_m_ctl;
    logic [ppds_pkg::PROD_W-1:0]  r_m_r, r_m_g, r_m_b;

    logic                         r_vld;
    logic [ppds_pkg::CH_W-1:0]    r_red, r_green, r_blue, n_red, n_green, n_blue;
    logic                         r_in_range, r_visible, n_in_range, n_visible;

    always_comb begin
        if (i_ctl.empty) begin
            fac = i_ctl.body ? ppds_pkg::F_FLAT_BODY : ppds_pkg::F_FLAT_MAT;
        end else begin
            fac = i_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl <= '0;
        end else if (i_en) begin
            r_m_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_r <= ppds_pkg::PROD_W'(i_ctl.r) * ppds_pkg::PROD_W'(fac);
            r_m_g <= ppds_pkg::PROD_W'(i_ctl.g) * ppds_pkg::PROD_W'(fac);
            r_m_b <= ppds_pkg::PROD_W'(i_ctl.b) * ppds_pkg::PROD_W'(fac);
        end
    end

    always_comb begin
        n_red      = '0;
        n_green    = '0;
        n_blue     = '0;
        n_in_range = r_m_ctl.ok;
        n_visible  = 1'b0;
        unique case (r_m_ctl.op)
            ppds_pkg::OP_WRITE: begin
            end
            ppds_pkg::OP_SHADE: begin
                if (!r_m_ctl.ok) begin
                    // out-of-range label: white, no shading
                    n_red   = ppds_pkg::CH_MAX;
                    n_green = ppds_pkg::CH_MAX;
                    n_blue  = ppds_pkg::CH_MAX;
                end else if (r_m_ctl.shade) begin
                    n_red   = sat_ch(r_m_r);
                    n_green = sat_ch(r_m_g);
                    n_blue  = sat_ch(r_m_b);
                end else begin
                    n_red   = r_m_ctl.r;
                    n_green = r_m_ctl.g;
                    n_blue  = r_m_ctl.b;
                end
            end
            ppds_pkg::OP_CLEAR: begin
                n_in_range = 1'b0;
            end
            ppds_pkg::OP_QUERY: begin
                n_visible = r_m_ctl.vis;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_m_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red      <= n_red;
            r_green    <= n_green;
            r_blue     <= n_blue;
            r_in_range <= n_in_range;
            r_visible  <= n_visible;
        end
    end

    assign o_valid    = r_vld;
    assign o_red      = r_red;
    assign o_green    = r_green;
    assign o_blue     = r_blue;
    assign o_in_range = r_in_range;
    assign o_visible  = r_visible;

endmodule

@@ sv/palette_pixel_depth_shader.sv @@
// Top level of the palette pixel depth shader: config registers and the pipeline.
// One item is accepted per clock while the output is not stalled, and each gives
// one result after two front stages (depth range math with the palette and
// visible-map access, then numerator and denominator), eight divider stages
// retiring two quotient bits each for the Q1.15 depth factor, one multiply stage
// and the output register. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stall on the output holds every
// stage in place. Palette entries and visible flags read as zero after reset with
// no clearing pass, and a clear operation empties the visible map. Configuration
// writes are taken at any time and must be made while the pipeline is empty.
module palette_pixel_depth_shader (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [ppds_pkg::LABEL_W-1:0]  i_label,
    input  logic [ppds_pkg::DEPTH_W-1:0]  i_depth,
    input  logic [ppds_pkg::CH_W-1:0]     i_write_red,
    input  logic [ppds_pkg::CH_W-1:0]     i_write_green,
    input  logic [ppds_pkg::CH_W-1:0]     i_write_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ppds_pkg::CH_W-1:0]     o_red,
    output logic [ppds_pkg::CH_W-1:0]     o_green,
    output logic [ppds_pkg::CH_W-1:0]     o_blue,
    output logic                          o_in_range,
    output logic                          o_visible,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [ppds_pkg::DEPTH_W-1:0]  i_cfg_data
);

    logic                          en;
    logic                          r_body_view;
    logic                          r_depth_shading;
    logic [ppds_pkg::DEPTH_W-1:0]  r_min_depth;
    logic [ppds_pkg::DEPTH_W-1:0]  r_max_depth;

    ppds_pkg::t_ctl ctl [ppds_pkg::DIV_STAGES+1];
    ppds_pkg::t_div div [ppds_pkg::DIV_STAGES+1];

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_view     <= 1'b0;
            r_depth_shading <= 1'b0;
            r_min_depth     <= '0;
            r_max_depth     <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ppds_pkg::CFG_BODY_VIEW:     r_body_view     <= i_cfg_data[0];
                ppds_pkg::CFG_DEPTH_SHADING: r_depth_shading <= i_cfg_data[0];
                ppds_pkg::CFG_MIN_DEPTH:     r_min_depth     <= i_cfg_data;
                ppds_pkg::CFG_MAX_DEPTH:     r_max_depth     <= i_cfg_data;
            endcase
        end
    end

    ppds_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_opcode        (i_opcode),
        .i_label         (i_label),
        .i_depth         (i_depth),
        .i_write_red     (i_write_red),
        .i_write_green   (i_write_green),
        .i_write_blue    (i_write_blue),
        .i_body_view     (r_body_view),
        .i_depth_shading (r_depth_shading),
        .i_min_depth     (r_min_depth),
        .i_max_depth     (r_max_depth),
        .o_ctl           (ctl[0]),
        .o_div           (div[0])
    );

    for (genvar s = 0; s < ppds_pkg::DIV_STAGES; s++) begin : g_div
        ppds_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[s]),
            .i_div   (div[s]),
            .o_ctl   (ctl[s+1]),
            .o_div   (div[s+1])
        );
    end

    ppds_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (ctl[ppds_pkg::DIV_STAGES]),
        .i_quot     (div[ppds_pkg::DIV_STAGES].q),
        .o_valid    (o_valid),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue),
        .o_in_range (o_in_range),
        .o_visible  (o_visible)
    );

endmodule

@@ sv/ppds_checker.sv @@
// Port-level checker for the palette pixel depth shader, bound to the top level.
module ppds_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [ppds_pkg::CH_W-1:0]     o_red,
    input logic [ppds_pkg::CH_W-1:0]     o_green,
    input logic [ppds_pkg::CH_W-1:0]     o_blue,
    input logic                          o_in_range,
    input logic                          o_visible
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_in_range) && $stable(o_visible))
        else $error("result changed while stalled");

    // A stalled output must stall the input side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    a_vis_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> o_in_range && o_red == '0 && o_green == '0
            && o_blue == '0)
        else $error("visible flag on a non-query result");

    // Out-of-range results carry either no color or white
    a_out_of_range_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_range && (o_red != '0 || o_green != '0 || o_blue != '0)
            |-> o_red == ppds_pkg::CH_MAX && o_green == ppds_pkg::CH_MAX
            && o_blue == ppds_pkg::CH_MAX)
        else $error("out-of-range color is not white");

endmodule

bind palette_pixel_depth_shader ppds_checker u_ppds_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_red      (o_red),
    .o_green    (o_green),
    .o_blue     (o_blue),
    .o_in_range (o_in_range),
    .o_visible  (o_visible)
);
